/* hdl/bpc_pkg.sv */
package bpc_pkg;

    // Item payloads
    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic [31:0] pressure_pa;
        logic        divisor_zero;
    } out_item_t;

    // Flags that ride alongside the divider
    typedef struct packed {
        logic zero;
        logic dbl;
    } div_side_t;

    // Register indexes
    localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [1:0] REG_PCAL_LOW  = 2'd1;
    localparam logic [1:0] REG_PCAL_HIGH = 2'd2;
    localparam logic [1:0] REG_PCAL_LAST = 2'd3;

    localparam logic [31:0] PRESS_OFFSET_T = 32'd64000;
    localparam logic [31:0] RAW_FULL_SCALE = 32'd1048576;
    localparam logic [31:0] PRESS_SCALE    = 32'd3125;
    localparam logic [31:0] HALF_RANGE     = 32'h8000_0000;
    localparam logic [31:0] P1_BIAS        = 32'd32768;

    localparam int DIV_STAGES = 32;

    // Arithmetic shift right of a 32-bit word
    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    // Sign-extend a 16-bit coefficient
    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

/* hdl/baro_pressure_compensation_core.sv */
// Channel   Handshake                Payload
// in        in_valid / in_ready      in_item  (raw_temperature, raw_pressure)
// out       out_valid / out_ready    out_item (pressure_pa, divisor_zero)
// config    APB psel/penable/pready  paddr[4:3] selects register, 64-bit data
//
// One item per cycle sustained while the output is not stalled; 8 arithmetic stages,
// 32 divider stages (one bit per stage) and 3 correction stages.
// rst_n clears valid bits and calibration registers.
// A stalled output freezes the whole pipeline; in_ready follows the output stall.
module baro_pressure_compensation_core
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // Calibration registers
    logic [47:0] temp_cal_reg;
    logic [63:0] pcal_low_reg;
    logic [63:0] pcal_high_reg;
    logic [15:0] pcal_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg  <= '0;
            pcal_low_reg  <= '0;
            pcal_high_reg <= '0;
            pcal_last_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:3])
                REG_TEMP_CAL:  temp_cal_reg  <= pwdata[47:0];
                REG_PCAL_LOW:  pcal_low_reg  <= pwdata;
                REG_PCAL_HIGH: pcal_high_reg <= pwdata;
                REG_PCAL_LAST: pcal_last_reg <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_TEMP_CAL:  prdata = {16'd0, temp_cal_reg};
            REG_PCAL_LOW:  prdata = pcal_low_reg;
            REG_PCAL_HIGH: prdata = pcal_high_reg;
            REG_PCAL_LAST: prdata = {48'd0, pcal_last_reg};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Coefficients
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = {16'd0, temp_cal_reg[15:0]};
    assign t2 = sx16(temp_cal_reg[31:16]);
    assign t3 = sx16(temp_cal_reg[47:32]);
    assign p1 = {16'd0, pcal_low_reg[15:0]};
    assign p2 = sx16(pcal_low_reg[31:16]);
    assign p3 = sx16(pcal_low_reg[47:32]);
    assign p4 = sx16(pcal_low_reg[63:48]);
    assign p5 = sx16(pcal_high_reg[15:0]);
    assign p6 = sx16(pcal_high_reg[31:16]);
    assign p7 = sx16(pcal_high_reg[47:32]);
    assign p8 = sx16(pcal_high_reg[63:48]);
    assign p9 = sx16(pcal_last_reg);

    // Global advance
    logic        en;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    logic [8:1]  vld_reg;
    logic        sa_vld_reg, sb_vld_reg;

    logic [31:0] s1_at2_reg, s1_bb_reg;
    logic [19:0] s1_adcp_reg, s2_adcp_reg, s3_adcp_reg, s4_adcp_reg;
    logic [19:0] s5_adcp_reg, s6_adcp_reg;
    logic [31:0] s2_v1t_reg, s2_x3_reg;
    logic [31:0] s3_v1_reg;
    logic [31:0] s4_sq_reg, s4_v1p5_reg, s4_p2v1_reg;
    logic [31:0] s5_sqp6_reg, s5_p3sq_reg, s5_v1p5_reg, s5_p2v1_reg;
    logic [31:0] s6_v2_reg, s6_v1_reg;
    logic [31:0] s7_m1_reg, s7_pnum_reg;
    logic [31:0] s8_d_reg, s8_p_reg;

    // Stage arithmetic
    logic [31:0] a_next, b_next, tfine_next, q_next;
    assign a_next     = ({12'd0, in_item.raw_temperature} >> 3) - (t1 << 1);
    assign b_next     = ({12'd0, in_item.raw_temperature} >> 4) - t1;
    assign tfine_next = s2_v1t_reg + asr32(s2_x3_reg, 14);
    assign q_next     = asr32(s3_v1_reg, 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // fine temperature products
            s1_at2_reg  <= a_next * t2;
            s1_bb_reg   <= b_next * b_next;
            s1_adcp_reg <= in_item.raw_pressure;

            s2_v1t_reg  <= asr32(s1_at2_reg, 11);
            s2_x3_reg   <= asr32(s1_bb_reg, 12) * t3;
            s2_adcp_reg <= s1_adcp_reg;

            s3_v1_reg   <= asr32(tfine_next, 1) - PRESS_OFFSET_T;
            s3_adcp_reg <= s2_adcp_reg;

            // first-order pressure terms
            s4_sq_reg   <= q_next * q_next;
            s4_v1p5_reg <= s3_v1_reg * p5;
            s4_p2v1_reg <= p2 * s3_v1_reg;
            s4_adcp_reg <= s3_adcp_reg;

            s5_sqp6_reg <= asr32(s4_sq_reg, 11) * p6;
            s5_p3sq_reg <= p3 * asr32(s4_sq_reg, 13);
            s5_v1p5_reg <= s4_v1p5_reg;
            s5_p2v1_reg <= s4_p2v1_reg;
            s5_adcp_reg <= s4_adcp_reg;

            s6_v2_reg   <= asr32(s5_sqp6_reg + (s5_v1p5_reg << 1), 2) + (p4 << 16);
            s6_v1_reg   <= asr32(asr32(s5_p3sq_reg, 3) + asr32(s5_p2v1_reg, 1), 18);
            s6_adcp_reg <= s5_adcp_reg;

            s7_m1_reg   <= (P1_BIAS + s6_v1_reg) * p1;
            s7_pnum_reg <= (RAW_FULL_SCALE - {12'd0, s6_adcp_reg}) - asr32(s6_v2_reg, 12);

            s8_d_reg    <= asr32(s7_m1_reg, 15);
            s8_p_reg    <= s7_pnum_reg * PRESS_SCALE;
        end
    end

    // Divide set-up
    div_side_t   div_in_side, div_out_side;
    logic [31:0] div_num, div_quo;
    logic        div_out_vld;
    assign div_in_side.zero = (s8_d_reg == '0);
    assign div_in_side.dbl  = (s8_p_reg >= HALF_RANGE);
    assign div_num          = div_in_side.dbl ? s8_p_reg : (s8_p_reg << 1);

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_reg[8]),
        .num      (div_num),
        .den      (s8_d_reg),
        .in_side  (div_in_side),
        .out_vld  (div_out_vld),
        .quo      (div_quo),
        .out_side (div_out_side)
    );

    // Second-order correction
    logic [31:0] qp_next, s_next, w1_next, pfin_next;
    logic [31:0] sa_p_reg, sa_ss_reg, sa_m8_reg, sb_p_reg, sb_m9_reg, sb_w2_reg;
    logic        sa_zero_reg, sb_zero_reg;

    assign qp_next   = div_out_side.dbl ? (div_quo << 1) : div_quo;
    assign s_next    = qp_next >> 3;
    assign w1_next   = asr32(sb_m9_reg, 12);
    assign pfin_next = sb_p_reg + asr32(w1_next + sb_w2_reg + p7, 4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_vld_reg    <= 1'b0;
            sb_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sa_vld_reg    <= div_out_vld;
            sb_vld_reg    <= sa_vld_reg;
            out_valid_reg <= sb_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_p_reg    <= qp_next;
            sa_ss_reg   <= s_next * s_next;
            sa_m8_reg   <= (qp_next >> 2) * p8;
            sa_zero_reg <= div_out_side.zero;

            sb_p_reg    <= sa_p_reg;
            sb_m9_reg   <= p9 * (sa_ss_reg >> 13);
            sb_w2_reg   <= asr32(sa_m8_reg, 13);
            sb_zero_reg <= sa_zero_reg;

            out_item_reg.pressure_pa  <= sb_zero_reg ? '0 : pfin_next;
            out_item_reg.divisor_zero <= sb_zero_reg;
        end
    end

endmodule

/* hdl/bpc_div.sv */
// Unsigned 32 / 32 divider, one quotient bit per pipeline stage
module bpc_div
    import bpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [31:0] num,
    input  logic [31:0] den,
    input  div_side_t   in_side,
    output logic        out_vld,
    output logic [31:0] quo,
    output div_side_t   out_side
);

    logic              vld_reg  [DIV_STAGES];
    logic [31:0]       rem_reg  [DIV_STAGES];
    logic [31:0]       nq_reg   [DIV_STAGES];
    logic [31:0]       den_reg  [DIV_STAGES];
    div_side_t         side_reg [DIV_STAGES];

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++) begin : g_stage
            logic [31:0] rem_in;
            logic [31:0] nq_in;
            logic [31:0] den_in;
            logic        vld_in;
            div_side_t   side_in;
            logic [32:0] trial;
            logic        fits;
            logic [32:0] diff;

            if (i == 0) begin : g_first
                assign rem_in  = '0;
                assign nq_in   = num;
                assign den_in  = den;
                assign vld_in  = in_vld;
                assign side_in = in_side;
            end
            else begin : g_rest
                assign rem_in  = rem_reg[i-1];
                assign nq_in   = nq_reg[i-1];
                assign den_in  = den_reg[i-1];
                assign vld_in  = vld_reg[i-1];
                assign side_in = side_reg[i-1];
            end

            // Shift in the next dividend bit and try a subtract
            assign trial = {rem_in, nq_in[31]};
            assign diff  = trial - {1'b0, den_in};
            assign fits  = (trial >= {1'b0, den_in});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= fits ? diff[31:0] : trial[31:0];
                    nq_reg[i]   <= {nq_in[30:0], fits};
                    den_reg[i]  <= den_in;
                    side_reg[i] <= side_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign quo      = nq_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule
